/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge of clk outside reset.
`define CHK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CHK_ALWAYS(label, prop)
`define CHK_NEXT(label, ante, cons)

`endif

`endif

/* rtl/tdsp_pkg.sv */
// Types and constants of the tick-driven stepper and soft PWM timer.
`default_nettype none

package tdsp_pkg;

  localparam logic [2:0] TICK_DIV_RELOAD = 3'd5;

  typedef enum logic [1:0] {
    CFG_STEP_DIV_A = 2'd0,
    CFG_STEP_DIV_B = 2'd1,
    CFG_DIAG_MODE  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic        move_req_a;
    logic [15:0] move_steps_a;
    logic        move_req_b;
    logic [15:0] move_steps_b;
    logic [5:0]  idle_valve_duty;
    logic [5:0]  power_valve_duty;
    logic [4:0]  purge_duty;
    logic [3:0]  fan_duty;
  } in_item_t;

  typedef struct packed {
    logic        step_pin_a;
    logic        step_pin_b;
    logic [15:0] steps_done_a;
    logic [15:0] steps_done_b;
    logic        request_taken_a;
    logic        request_taken_b;
    logic        idle_valve_pin;
    logic        power_valve_pin;
    logic        purge_pin;
    logic        fan_pin;
    logic [15:0] tick_count;
    logic        adc_start;
  } out_item_t;

  // Per-channel stepper status after the current tick.
  typedef struct packed {
    logic        pin;
    logic [15:0] done_count;
    logic        taken;
  } step_stat_t;

endpackage

`default_nettype wire

/* rtl/tdsp_if.sv */
// Valid/ready channel interfaces for tick items, results and configuration writes.
`default_nettype none

interface tdsp_in_if;
  logic               valid;
  logic               ready;
  tdsp_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tdsp_out_if;
  logic                valid;
  logic                ready;
  tdsp_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tdsp_cfg_if;
  logic                 valid;
  logic                 ready;
  tdsp_pkg::cfg_index_t index;
  logic [7:0]           wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/tdsp_stepper.sv */
// One stepper channel: tick divider, pending request, step pulse and done counter.
`default_nettype none

module tdsp_stepper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 freeze,
  input  logic                 post,
  input  logic [15:0]          post_steps,
  input  logic [7:0]           divider,
  output tdsp_pkg::step_stat_t stat
);

  logic [7:0]  phase_count, phase_count_next;
  logic        pulse_high, pulse_high_next;
  logic        pending, pending_next;
  logic [15:0] pending_steps, pending_steps_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] done_count, done_count_next;
  logic        taken;
  logic [15:0] rem_eff;

  always_comb begin
    // a request posted on this tick is visible to this tick's step phase
    pending_next       = post ? 1'b1 : pending;
    pending_steps_next = post ? post_steps : pending_steps;
    phase_count_next   = phase_count;
    pulse_high_next    = pulse_high;
    remaining_next     = remaining;
    done_count_next    = done_count;
    taken              = 1'b0;
    rem_eff            = remaining;
    if (!freeze) begin
      if (phase_count != 8'd0) begin
        phase_count_next = phase_count - 8'd1;
      end else begin
        phase_count_next = divider;
        if (!pulse_high && pending_next) begin
          taken        = 1'b1;
          rem_eff      = pending_steps_next;
          pending_next = 1'b0;
        end
        remaining_next = rem_eff;
        if (rem_eff != 16'd0) begin
          if (!pulse_high) begin
            pulse_high_next = 1'b1;
          end else begin
            pulse_high_next = 1'b0;
            remaining_next  = rem_eff - 16'd1;
            done_count_next = done_count + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count   <= '0;
      pulse_high    <= 1'b0;
      pending       <= 1'b0;
      pending_steps <= '0;
      remaining     <= '0;
      done_count    <= '0;
    end else if (accept) begin
      phase_count   <= phase_count_next;
      pulse_high    <= pulse_high_next;
      pending       <= pending_next;
      pending_steps <= pending_steps_next;
      remaining     <= remaining_next;
      done_count    <= done_count_next;
    end
  end

  assign stat.pin        = pulse_high_next;
  assign stat.done_count = done_count_next;
  assign stat.taken      = taken;

endmodule

`default_nettype wire

/* rtl/tick_driven_stepper_and_soft_pwm_timer.sv */
// Top level of the tick-driven stepper and soft PWM timer.
//
// Each request on req is one timer tick carrying step-count requests for
// stepper channels A and B and the duties of the valve, purge and fan PWMs.
// Every tick produces exactly one result on rsp: step pin levels, done
// counts, request acknowledges, PWM pin levels, the divided tick count and
// the ADC start strobe, all as they stand after that tick.
// The result is in the output register in the cycle after the tick is
// accepted. Throughput is one tick per cycle while rsp is ready; all state
// updates are counter compares ahead of the output register.
// A new tick is taken while the previous result is being taken; when the
// receiver stalls the result holds and req.ready drops until it is taken.
// cfg writes step_divider_a, step_divider_b and diag_mode; it is always
// ready and must only be used while no result is outstanding.
// Synchronous reset clears all counters, pins and pending requests, loads
// the tick prescaler with five and empties the output register.
`default_nettype none

module tick_driven_stepper_and_soft_pwm_timer (
  input  logic              clk,
  input  logic              rst,
  tdsp_in_if.sink           req,
  tdsp_out_if.source        rsp,
  tdsp_cfg_if.sink          cfg
);

  logic [7:0]  step_divider_a;
  logic [7:0]  step_divider_b;
  logic        diag_mode;

  logic [5:0]  valve_phase, valve_phase_next;
  logic [5:0]  idle_compare, idle_compare_next;
  logic [5:0]  power_compare, power_compare_next;
  logic        idle_pin, idle_pin_next;
  logic        power_pin, power_pin_next;
  logic [4:0]  purge_phase, purge_phase_next;
  logic [4:0]  purge_compare, purge_compare_next;
  logic        purge_pin, purge_pin_next;
  logic [3:0]  fan_phase, fan_phase_next;
  logic [3:0]  fan_compare, fan_compare_next;
  logic        fan_pin, fan_pin_next;
  logic [2:0]  tick_prescale, tick_prescale_next;
  logic [15:0] system_ticks, system_ticks_next;
  logic [1:0]  adc_prescale;

  logic                 out_valid;
  tdsp_pkg::out_item_t  out_item, out_item_next;
  tdsp_pkg::step_stat_t stat_a, stat_b;
  logic                 accept;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_divider_a <= '0;
      step_divider_b <= '0;
      diag_mode      <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tdsp_pkg::CFG_STEP_DIV_A: step_divider_a <= cfg.wdata;
        tdsp_pkg::CFG_STEP_DIV_B: step_divider_b <= cfg.wdata;
        tdsp_pkg::CFG_DIAG_MODE:  diag_mode      <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  tdsp_stepper u_step_a (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .freeze     (diag_mode),
    .post       (req.data.move_req_a),
    .post_steps (req.data.move_steps_a),
    .divider    (step_divider_a),
    .stat       (stat_a)
  );

  tdsp_stepper u_step_b (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .freeze     (diag_mode),
    .post       (req.data.move_req_b),
    .post_steps (req.data.move_steps_b),
    .divider    (step_divider_b),
    .stat       (stat_b)
  );

  // valve PWMs: duty loads at wrap, pin drops on compare match
  always_comb begin
    valve_phase_next   = valve_phase;
    idle_compare_next  = idle_compare;
    power_compare_next = power_compare;
    idle_pin_next      = idle_pin;
    power_pin_next     = power_pin;
    if (!diag_mode) begin
      valve_phase_next = valve_phase + 6'd1;
      if (valve_phase_next == 6'd0) begin
        idle_compare_next  = req.data.idle_valve_duty;
        power_compare_next = req.data.power_valve_duty;
        idle_pin_next      = 1'b1;
        power_pin_next     = 1'b1;
      end
      if (idle_compare_next == valve_phase_next) idle_pin_next = 1'b0;
      if (power_compare_next == valve_phase_next) power_pin_next = 1'b0;
    end
  end

  // purge and fan PWMs halt while their duty is zero
  always_comb begin
    purge_phase_next   = purge_phase;
    purge_compare_next = purge_compare;
    purge_pin_next     = purge_pin;
    if (req.data.purge_duty != 5'd0) begin
      purge_phase_next = purge_phase + 5'd1;
      if (purge_phase_next == 5'd0) begin
        purge_compare_next = req.data.purge_duty;
        purge_pin_next     = 1'b1;
      end
      if (purge_compare_next == purge_phase_next) purge_pin_next = 1'b0;
    end
  end

  always_comb begin
    fan_phase_next   = fan_phase;
    fan_compare_next = fan_compare;
    fan_pin_next     = fan_pin;
    if (req.data.fan_duty != 4'd0) begin
      fan_phase_next = fan_phase + 4'd1;
      if (fan_phase_next == 4'd0) begin
        fan_compare_next = req.data.fan_duty;
        fan_pin_next     = 1'b1;
      end
      if (fan_compare_next == fan_phase_next) fan_pin_next = 1'b0;
    end
  end

  always_comb begin
    if (tick_prescale != 3'd0) begin
      tick_prescale_next = tick_prescale - 3'd1;
      system_ticks_next  = system_ticks;
    end else begin
      tick_prescale_next = tdsp_pkg::TICK_DIV_RELOAD;
      system_ticks_next  = system_ticks + 16'd1;
    end
  end

  always_comb begin
    out_item_next.step_pin_a      = stat_a.pin;
    out_item_next.step_pin_b      = stat_b.pin;
    out_item_next.steps_done_a    = stat_a.done_count;
    out_item_next.steps_done_b    = stat_b.done_count;
    out_item_next.request_taken_a = stat_a.taken;
    out_item_next.request_taken_b = stat_b.taken;
    out_item_next.idle_valve_pin  = idle_pin_next;
    out_item_next.power_valve_pin = power_pin_next;
    out_item_next.purge_pin       = purge_pin_next;
    out_item_next.fan_pin         = fan_pin_next;
    out_item_next.tick_count      = system_ticks_next;
    out_item_next.adc_start       = (adc_prescale == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valve_phase   <= '0;
      idle_compare  <= '0;
      power_compare <= '0;
      idle_pin      <= 1'b0;
      power_pin     <= 1'b0;
      purge_phase   <= '0;
      purge_compare <= '0;
      purge_pin     <= 1'b0;
      fan_phase     <= '0;
      fan_compare   <= '0;
      fan_pin       <= 1'b0;
      tick_prescale <= tdsp_pkg::TICK_DIV_RELOAD;
      system_ticks  <= '0;
      adc_prescale  <= '0;
    end else if (accept) begin
      valve_phase   <= valve_phase_next;
      idle_compare  <= idle_compare_next;
      power_compare <= power_compare_next;
      idle_pin      <= idle_pin_next;
      power_pin     <= power_pin_next;
      purge_phase   <= purge_phase_next;
      purge_compare <= purge_compare_next;
      purge_pin     <= purge_pin_next;
      fan_phase     <= fan_phase_next;
      fan_compare   <= fan_compare_next;
      fan_pin       <= fan_pin_next;
      tick_prescale <= tick_prescale_next;
      system_ticks  <= system_ticks_next;
      adc_prescale  <= adc_prescale + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= out_item_next;
    end
  end

`include "assert_macros.svh"

  `CHK_NEXT(a_result_follows_tick, accept, out_valid)
  `CHK_NEXT(a_diag_no_take, accept && diag_mode, !out_item.request_taken_a && !out_item.request_taken_b)
  `CHK_NEXT(a_ticks_hold, accept && tick_prescale != 3'd0, system_ticks == $past(system_ticks))
  `CHK_ALWAYS(a_prescale_range, tick_prescale <= tdsp_pkg::TICK_DIV_RELOAD)

endmodule

`default_nettype wire

/* verif/tick_driven_stepper_and_soft_pwm_timer_test.sv */
// Testbench for the tick-driven stepper and soft PWM timer: directed, random and stall tests.
`default_nettype none

module tick_driven_stepper_and_soft_pwm_timer_test;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  tdsp_in_if  req_if();
  tdsp_out_if rsp_if();
  tdsp_cfg_if cfg_if();

  tick_driven_stepper_and_soft_pwm_timer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // Predicted timer state
  typedef struct {
    logic [7:0]  phase;
    logic        pulse_high;
    logic        pending;
    logic [15:0] pending_steps;
    logic [15:0] remaining;
    logic [15:0] done;
  } motor_state_t;

  motor_state_t motor [2];
  logic [7:0]   divider [2];
  logic         diag_on;
  logic [5:0]   valve_phase, idle_cmp, power_cmp;
  logic [4:0]   purge_phase, purge_cmp;
  logic [3:0]   fan_phase, fan_cmp;
  logic         idle_pin, power_pin, purge_pin, fan_pin;
  logic [2:0]   tick_pre;
  logic [15:0]  sys_ticks;
  logic [1:0]   adc_pre;

  tdsp_pkg::out_item_t awaited_status [$];

  int  errors = 0;
  int  ticks_sent = 0;
  int  results_checked = 0;
  int  cfg_writes = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;
  bit  hold_used = 1'b0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_stalls_on = 1'b0;

  // One divided tick of a stepper channel; returns 1 when it took its request.
  function automatic logic step_motor(logic ch);
    logic took;
    took = 1'b0;
    if (motor[ch].phase != 8'd0) begin
      motor[ch].phase = motor[ch].phase - 8'd1;
    end else begin
      motor[ch].phase = divider[ch];
      if (!motor[ch].pulse_high && motor[ch].pending) begin
        motor[ch].remaining = motor[ch].pending_steps;
        motor[ch].pending   = 1'b0;
        took = 1'b1;
      end
      if (motor[ch].remaining != 16'd0) begin
        if (!motor[ch].pulse_high) begin
          motor[ch].pulse_high = 1'b1;
        end else begin
          motor[ch].pulse_high = 1'b0;
          motor[ch].remaining  = motor[ch].remaining - 16'd1;
          motor[ch].done       = motor[ch].done + 16'd1;
        end
      end
    end
    return took;
  endfunction

  function automatic void advance_timer_tick(tdsp_pkg::in_item_t t);
    tdsp_pkg::out_item_t s;
    s = '0;
    // new request is posted before the channel looks at it
    if (t.move_req_a) begin
      motor[0].pending       = 1'b1;
      motor[0].pending_steps = t.move_steps_a;
    end
    if (t.move_req_b) begin
      motor[1].pending       = 1'b1;
      motor[1].pending_steps = t.move_steps_b;
    end
    if (!diag_on) begin
      s.request_taken_a = step_motor(1'b0);
      s.request_taken_b = step_motor(1'b1);
      valve_phase = valve_phase + 6'd1;
      if (valve_phase == 6'd0) begin
        idle_cmp  = t.idle_valve_duty;
        power_cmp = t.power_valve_duty;
        idle_pin  = 1'b1;
        power_pin = 1'b1;
      end
      if (idle_cmp == valve_phase) idle_pin = 1'b0;
      if (power_cmp == valve_phase) power_pin = 1'b0;
    end
    if (t.purge_duty != 5'd0) begin
      purge_phase = purge_phase + 5'd1;
      if (purge_phase == 5'd0) begin
        purge_cmp = t.purge_duty;
        purge_pin = 1'b1;
      end
      if (purge_cmp == purge_phase) purge_pin = 1'b0;
    end
    if (t.fan_duty != 4'd0) begin
      fan_phase = fan_phase + 4'd1;
      if (fan_phase == 4'd0) begin
        fan_cmp = t.fan_duty;
        fan_pin = 1'b1;
      end
      if (fan_cmp == fan_phase) fan_pin = 1'b0;
    end
    if (tick_pre != 3'd0) begin
      tick_pre = tick_pre - 3'd1;
    end else begin
      tick_pre  = tdsp_pkg::TICK_DIV_RELOAD;
      sys_ticks = sys_ticks + 16'd1;
    end
    s.adc_start = (adc_pre == 2'd0);
    adc_pre = adc_pre + 2'd1;

    s.step_pin_a      = motor[0].pulse_high;
    s.step_pin_b      = motor[1].pulse_high;
    s.steps_done_a    = motor[0].done;
    s.steps_done_b    = motor[1].done;
    s.idle_valve_pin  = idle_pin;
    s.power_valve_pin = power_pin;
    s.purge_pin       = purge_pin;
    s.fan_pin         = fan_pin;
    s.tick_count      = sys_ticks;
    awaited_status.push_back(s);
    ticks_sent++;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Tracks config writes and accepted ticks, checks every taken result.
  always @(posedge clk) begin : result_checker
    tdsp_pkg::out_item_t want;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_status.size() == 0) begin
          errors++;
          $display("%0t: result with no tick outstanding, actual %0h", $time, rsp_if.data);
        end else begin
          want = awaited_status.pop_front();
          results_checked++;
          check_field("step_pin_a", want.step_pin_a, rsp_if.data.step_pin_a);
          check_field("step_pin_b", want.step_pin_b, rsp_if.data.step_pin_b);
          check_field("steps_done_a", want.steps_done_a, rsp_if.data.steps_done_a);
          check_field("steps_done_b", want.steps_done_b, rsp_if.data.steps_done_b);
          check_field("request_taken_a", want.request_taken_a, rsp_if.data.request_taken_a);
          check_field("request_taken_b", want.request_taken_b, rsp_if.data.request_taken_b);
          check_field("idle_valve_pin", want.idle_valve_pin, rsp_if.data.idle_valve_pin);
          check_field("power_valve_pin", want.power_valve_pin, rsp_if.data.power_valve_pin);
          check_field("purge_pin", want.purge_pin, rsp_if.data.purge_pin);
          check_field("fan_pin", want.fan_pin, rsp_if.data.fan_pin);
          check_field("tick_count", want.tick_count, rsp_if.data.tick_count);
          check_field("adc_start", want.adc_start, rsp_if.data.adc_start);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        cfg_writes++;
        case (cfg_if.index)
          tdsp_pkg::CFG_STEP_DIV_A: divider[0] = cfg_if.wdata;
          tdsp_pkg::CFG_STEP_DIV_B: divider[1] = cfg_if.wdata;
          tdsp_pkg::CFG_DIAG_MODE:  diag_on = cfg_if.wdata[0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready)
        advance_timer_tick(req_if.data);
    end
  end

  // Long receiver hold-off, loaded once when asked for and counted down here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_left <= 300;
      hold_used <= 1'b1;
    end
  end

  initial begin : result_receiver
    int stall;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 15) : 0;
      if (stall != 0 || hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_left != 0) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // valid stays high after acceptance; the next request or a drain decides.
  task automatic send_tick(input tdsp_pkg::in_item_t t);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= t;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  task automatic set_config(input logic [7:0] div_a, input logic [7:0] div_b, input logic diag);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= tdsp_pkg::CFG_STEP_DIV_A;
    cfg_if.wdata <= div_a;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.index <= tdsp_pkg::CFG_STEP_DIV_B;
    cfg_if.wdata <= div_b;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.index <= tdsp_pkg::CFG_DIAG_MODE;
    cfg_if.wdata <= {7'd0, diag};
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained;
    req_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic tdsp_pkg::in_item_t make_tick(logic ra, logic [15:0] sa, logic rb,
                                                   logic [15:0] sb, logic [5:0] iv,
                                                   logic [5:0] pv, logic [4:0] pu,
                                                   logic [3:0] fa);
    tdsp_pkg::in_item_t t;
    t.move_req_a       = ra;
    t.move_steps_a     = sa;
    t.move_req_b       = rb;
    t.move_steps_b     = sb;
    t.idle_valve_duty  = iv;
    t.power_valve_duty = pv;
    t.purge_duty       = pu;
    t.fan_duty         = fa;
    return t;
  endfunction

  // Mostly short moves so pulses finish; now and then a full-range count.
  function automatic tdsp_pkg::in_item_t random_tick(int steps_max);
    tdsp_pkg::in_item_t t;
    t.move_req_a       = ($urandom_range(0, 5) == 0);
    t.move_steps_a     = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, steps_max));
    t.move_req_b       = ($urandom_range(0, 5) == 0);
    t.move_steps_b     = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, steps_max));
    t.idle_valve_duty  = 6'($urandom);
    t.power_valve_duty = 6'($urandom);
    t.purge_duty       = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom);
    t.fan_duty         = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom);
    return t;
  endfunction

  task automatic run_phase(input logic [7:0] div_a, input logic [7:0] div_b, input logic diag,
                           input bit gaps, input bit stalls, input int count,
                           input int steps_max);
    set_config(div_a, div_b, diag);
    tx_gaps_on   = gaps;
    rx_stalls_on = stalls;
    repeat (count) send_tick(random_tick(steps_max));
    wait_drained();
  endtask

  // Zero-step moves, request while pulse high, same-tick post and take,
  // max counts, duty extremes and purge/fan halt, then divider extremes.
  task automatic test_requests_and_pwm;
    set_config(8'd0, 8'd0, 1'b0);
    send_tick(make_tick(1'b1, 16'd0, 1'b1, 16'd0, 6'd63, 6'd63, 5'd31, 4'd15));
    send_tick(make_tick(1'b1, 16'd2, 1'b0, 16'd0, 6'd1, 6'd0, 5'd1, 4'd1));
    send_tick(make_tick(1'b1, 16'd5, 1'b0, 16'hFFFF, 6'd0, 6'd63, 5'd0, 4'd0));
    send_tick(make_tick(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 6'd32, 6'd32, 5'd16, 4'd8));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd63, 6'd0, 5'd31, 4'd15));
    send_tick(make_tick(1'b1, 16'hFFFF, 1'b1, 16'd1, 6'd0, 6'd0, 5'd0, 4'd0));
    send_tick(make_tick(1'b0, 16'h5555, 1'b0, 16'hAAAA, 6'd21, 6'd42, 5'd10, 4'd5));
    send_tick(make_tick(1'b1, 16'h8000, 1'b1, 16'd1, 6'd63, 6'd63, 5'd31, 4'd15));
    send_tick(make_tick(1'b0, 16'hAAAA, 1'b0, 16'h5555, 6'd42, 6'd21, 5'd21, 4'd10));
    send_tick(make_tick(1'b1, 16'd3, 1'b1, 16'd0, 6'd1, 6'd1, 5'd1, 4'd1));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd0, 6'd0, 5'd0, 4'd0));
    send_tick(make_tick(1'b0, 16'd0, 1'b1, 16'd2, 6'd63, 6'd63, 5'd31, 4'd15));
    wait_drained();
    set_config(8'd255, 8'd1, 1'b0);
    send_tick(make_tick(1'b1, 16'd4, 1'b1, 16'd4, 6'd10, 6'd20, 5'd3, 4'd3));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd10, 6'd20, 5'd3, 4'd3));
    send_tick(make_tick(1'b1, 16'd1, 1'b0, 16'd0, 6'd10, 6'd20, 5'd3, 4'd3));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd10, 6'd20, 5'd3, 4'd3));
    wait_drained();
  endtask

  // Requests post but stay pending while frozen; a newer count replaces an older one.
  task automatic test_diag_freeze;
    set_config(8'd0, 8'd0, 1'b1);
    send_tick(make_tick(1'b1, 16'd10, 1'b1, 16'd4, 6'd5, 6'd5, 5'd5, 4'd5));
    send_tick(make_tick(1'b1, 16'd3, 1'b0, 16'd0, 6'd5, 6'd5, 5'd5, 4'd5));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd5, 6'd5, 5'd5, 4'd5));
    wait_drained();
    set_config(8'd0, 8'd0, 1'b0);
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd5, 6'd5, 5'd5, 4'd5));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd5, 6'd5, 5'd5, 4'd5));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd5, 6'd5, 5'd5, 4'd5));
    send_tick(make_tick(1'b0, 16'd0, 1'b0, 16'd0, 6'd5, 6'd5, 5'd5, 4'd5));
    wait_drained();
  endtask

  task automatic test_random_traffic;
    run_phase(8'd0, 8'd0, 1'b0, 1'b1, 1'b1, 250, 6);
    run_phase(8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 200, 3);
    run_phase(8'd1, 8'd3, 1'b0, 1'b1, 1'b0, 200, 12);
    run_phase(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)), 1'b0, 1'b0, 1'b1, 250, 40);
    run_phase(8'd0, 8'd255, 1'b1, 1'b1, 1'b1, 100, 6);
    run_phase(8'd2, 8'd0, 1'b0, 1'b1, 1'b1, 200, 6);
    run_phase(8'd0, 8'd1, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 200, 4);
  endtask

  // Receiver holds off while ticks keep coming, so the block must stall its input.
  task automatic test_receiver_backpressure;
    set_config(8'd0, 8'd0, 1'b0);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_go      = 1'b1;
    repeat (40) send_tick(random_tick(5));
    wait_drained();
  endtask

  initial begin : test_sequence
    motor[0]    = '{8'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0};
    motor[1]    = '{8'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0};
    divider[0]  = 8'd0;
    divider[1]  = 8'd0;
    diag_on     = 1'b0;
    valve_phase = '0;
    idle_cmp    = '0;
    power_cmp   = '0;
    purge_phase = '0;
    purge_cmp   = '0;
    fan_phase   = '0;
    fan_cmp     = '0;
    idle_pin    = 1'b0;
    power_pin   = 1'b0;
    purge_pin   = 1'b0;
    fan_pin     = 1'b0;
    tick_pre    = tdsp_pkg::TICK_DIV_RELOAD;
    sys_ticks   = '0;
    adc_pre     = '0;

    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= tdsp_pkg::CFG_STEP_DIV_A;
    cfg_if.wdata <= 8'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_requests_and_pwm();
    test_diag_freeze();
    test_random_traffic();
    test_receiver_backpressure();

    $display("Covered %0d ticks: directed moves and duties, diagnostic freeze, random traffic",
             ticks_sent);
    $display("across divider extremes and a long output stall; %0d results, %0d reg writes",
             results_checked, cfg_writes);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
